### hw/rtl/ptt_pkg.sv
// ---------------------------------------------------------------------------
// Periodic timer table package
// Shared sizes, request and result codes, and the entry and control types.
// ---------------------------------------------------------------------------
package ptt_pkg;

   localparam int DEPTH        = 16;
   localparam int TIME_WIDTH   = 32;
   localparam int HANDLE_WIDTH = 32;
   localparam int LEAD_WIDTH   = 10;
   localparam int CODE_WIDTH   = 3;
   localparam int CNT_WIDTH    = $clog2(DEPTH + 1);

   localparam logic [LEAD_WIDTH-1:0] LEAD_RESET = LEAD_WIDTH'(1);

   // Request types.
   localparam logic [CODE_WIDTH-1:0] REQ_ADD     = 3'd0;
   localparam logic [CODE_WIDTH-1:0] REQ_CHANGE  = 3'd1;
   localparam logic [CODE_WIDTH-1:0] REQ_RESTART = 3'd2;
   localparam logic [CODE_WIDTH-1:0] REQ_REMOVE  = 3'd3;
   localparam logic [CODE_WIDTH-1:0] REQ_TICK    = 3'd4;

   // Result kinds.
   localparam logic [CODE_WIDTH-1:0] KIND_ADDED     = 3'd0;
   localparam logic [CODE_WIDTH-1:0] KIND_DONE      = 3'd1;
   localparam logic [CODE_WIDTH-1:0] KIND_NOT_FOUND = 3'd2;
   localparam logic [CODE_WIDTH-1:0] KIND_FULL      = 3'd3;
   localparam logic [CODE_WIDTH-1:0] KIND_FIRED     = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    valid;
      logic [HANDLE_WIDTH-1:0] handle;
      logic [TIME_WIDTH-1:0]   start;
      logic [TIME_WIDTH-1:0]   period;
   } entry_type;

   // Control sent from the sequencer to every cell of the chain.
   typedef struct packed {
      logic      step;
      logic      drop;
      logic      load;
      entry_type head;
      entry_type fresh;
   } chain_ctl_type;

endpackage

### hw/rtl/ptt_cell.sv
// ---------------------------------------------------------------------------
// Timer cell
// Holds one table entry and passes it toward the head of the chain.
// ---------------------------------------------------------------------------
module ptt_cell
   import ptt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CNT_WIDTH-1:0] idx,
   input  logic [CNT_WIDTH-1:0] cnt,
   input  chain_ctl_type        ctl,
   input  entry_type            nbr,
   output entry_type            entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic [CNT_WIDTH-1:0] idx_next;

   assign idx_next = idx + CNT_WIDTH'(1);

   // Live cells rotate toward cell zero; the cell at the tail of the live
   // run takes back the processed head entry unless it is being removed.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.load && (cnt == idx)) begin
         entry_in       = ctl.fresh;
         entry_in.valid = 1'b1;
      end else if (ctl.step) begin
         if (idx_next < cnt) begin
            entry_in = nbr;
         end else if (idx_next == cnt) begin
            if (ctl.drop) begin
               entry_in.valid = 1'b0;
            end else begin
               entry_in = ctl.head;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.handle <= entry_in.handle;
      entry_ff.start  <= entry_in.start;
      entry_ff.period <= entry_in.period;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign entry = entry_ff;

endmodule

### hw/rtl/ptt_ctrl.sv
// ---------------------------------------------------------------------------
// Timer table sequencer
// Takes requests, steps the cell chain once around for a tick, change, restart or remove, and forms the results.
// ---------------------------------------------------------------------------
module ptt_ctrl
   import ptt_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [3*TIME_WIDTH-1:0]     req_tdata,
   input  logic [CODE_WIDTH-1:0]       req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [HANDLE_WIDTH-1:0]     rsp_tdata,
   output logic [CODE_WIDTH-1:0]       rsp_tuser,
   output logic                        rsp_tlast,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [LEAD_WIDTH-1:0]       csr_data,
   input  entry_type                   head,
   output chain_ctl_type               ctl,
   output logic [CNT_WIDTH-1:0]        cnt
);

   state_type state_ff, state_in;

   logic [CODE_WIDTH-1:0]   type_ff, type_in;
   logic [TIME_WIDTH-1:0]   now_ff, now_in;
   logic [HANDLE_WIDTH-1:0] handle_ff, handle_in;
   logic [TIME_WIDTH-1:0]   interval_ff, interval_in;
   logic [CNT_WIDTH-1:0]    steps_ff, steps_in;
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;
   logic                    found_ff, found_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [CODE_WIDTH-1:0]   pend_kind_ff, pend_kind_in;
   logic [HANDLE_WIDTH-1:0] pend_handle_ff, pend_handle_in;
   logic [HANDLE_WIDTH-1:0] next_handle_ff, next_handle_in;
   logic [LEAD_WIDTH-1:0]   lead_ff, lead_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CODE_WIDTH-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_WIDTH-1:0] rsp_handle_ff, rsp_handle_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic                  is_add;
   logic                  is_tick;
   logic                  is_unknown;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  due;
   logic                  match;
   logic                  stall;
   logic                  push;
   logic                  push_last;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_add     = (type_ff == REQ_ADD);
   assign is_tick    = (type_ff == REQ_TICK);
   assign is_unknown = (type_ff > REQ_TICK);
   assign elapsed    = now_ff - head.start;
   assign due        = head.valid && (elapsed > head.period);
   assign match      = head.valid && !found_ff && (head.handle == handle_ff);
   // A new fire pushes the one held before it, which needs the output free.
   assign stall      = is_tick && due && pend_valid_ff && !out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (is_add || is_unknown || (steps_ff == '0)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      req_tready     = 1'b0;
      type_in        = type_ff;
      now_in         = now_ff;
      handle_in      = handle_ff;
      interval_in    = interval_ff;
      steps_in       = steps_ff;
      cnt_in         = cnt_ff;
      found_in       = found_ff;
      pend_valid_in  = pend_valid_ff;
      pend_kind_in   = pend_kind_ff;
      pend_handle_in = pend_handle_ff;
      next_handle_in = next_handle_ff;
      push           = 1'b0;
      push_last      = 1'b0;
      ctl            = '0;
      ctl.head       = head;
      ctl.fresh.valid  = 1'b1;
      ctl.fresh.handle = next_handle_ff;
      ctl.fresh.period = interval_ff;
      ctl.fresh.start  = now_ff - interval_ff - TIME_WIDTH'(lead_ff);

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               type_in        = req_tuser;
               now_in         = req_tdata[TIME_WIDTH-1:0];
               handle_in      = req_tdata[TIME_WIDTH +: HANDLE_WIDTH];
               interval_in    = req_tdata[TIME_WIDTH + HANDLE_WIDTH +: TIME_WIDTH];
               steps_in       = cnt_ff;
               found_in       = 1'b0;
               pend_valid_in  = (req_tuser == REQ_CHANGE) || (req_tuser == REQ_RESTART) ||
                                (req_tuser == REQ_REMOVE);
               pend_kind_in   = KIND_NOT_FOUND;
               pend_handle_in = req_tdata[TIME_WIDTH +: HANDLE_WIDTH];
            end
         end
         ST_SCAN: begin
            if (is_add) begin
               pend_valid_in = 1'b1;
               if (cnt_ff == CNT_WIDTH'(DEPTH)) begin
                  pend_kind_in   = KIND_FULL;
                  pend_handle_in = '0;
               end else begin
                  ctl.load       = 1'b1;
                  pend_kind_in   = KIND_ADDED;
                  pend_handle_in = next_handle_ff;
                  next_handle_in = next_handle_ff + HANDLE_WIDTH'(1);
                  cnt_in         = cnt_ff + CNT_WIDTH'(1);
               end
            end else if (!is_unknown && (steps_ff != '0) && !stall) begin
               ctl.step = 1'b1;
               steps_in = steps_ff - CNT_WIDTH'(1);
               if (is_tick) begin
                  if (due) begin
                     ctl.head.start = head.start + head.period;
                     push           = pend_valid_ff;
                     pend_valid_in  = 1'b1;
                     pend_kind_in   = KIND_FIRED;
                     pend_handle_in = head.handle;
                  end
               end else if (match) begin
                  found_in     = 1'b1;
                  pend_kind_in = KIND_DONE;
                  if (type_ff == REQ_CHANGE) begin
                     ctl.head.period = interval_ff;
                  end else if (type_ff == REQ_RESTART) begin
                     ctl.head.start = now_ff;
                  end else begin
                     ctl.drop = 1'b1;
                     cnt_in   = cnt_ff - CNT_WIDTH'(1);
                  end
               end
            end
         end
         ST_DONE: begin
            if (pend_valid_ff && out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Result register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_last_in   = rsp_last_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = pend_kind_ff;
         rsp_handle_in = pend_handle_ff;
         rsp_last_in   = push_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      csr_ready = 1'b1;
      lead_in   = lead_ff;
      if (csr_valid) begin
         lead_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      type_ff        <= type_in;
      now_ff         <= now_in;
      handle_ff      <= handle_in;
      interval_ff    <= interval_in;
      steps_ff       <= steps_in;
      found_ff       <= found_in;
      pend_kind_ff   <= pend_kind_in;
      pend_handle_ff <= pend_handle_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         pend_valid_ff  <= 1'b0;
         next_handle_ff <= '0;
         lead_ff        <= LEAD_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         pend_valid_ff  <= pend_valid_in;
         next_handle_ff <= next_handle_in;
         lead_ff        <= lead_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_handle_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign cnt        = cnt_ff;

endmodule

### hw/rtl/periodic_timer_table.sv
// ---------------------------------------------------------------------------
// Periodic timer table
// Ordered table of periodic timers kept in a rotating chain of cells.
// ---------------------------------------------------------------------------
//   Channel   Direction  Accepted when             Carries
//   req_      in         req_tvalid & req_tready   tuser: type; tdata: now, handle, interval
//   rsp_      out        rsp_tvalid & rsp_tready   tuser: kind; tdata: handle; tlast: last
//   csr_      in         csr_valid & csr_ready     start_lead
//
// For a tick, change, restart or remove, the chain rotates once around its
// live entries, one entry per cycle through the head cell, except while paused.
// An add or a request of unknown type does not rotate the chain.
// The rotation pauses while a fire result waits on a stalled output.
// Reset empties the table; start_lead returns to 1.
// ---------------------------------------------------------------------------
module periodic_timer_table
   import ptt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // now [31:0], handle [63:32], interval [95:64]
   input  logic [3*TIME_WIDTH-1:0] req_tdata,
   // req_type [2:0]
   input  logic [CODE_WIDTH-1:0]   req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // result_handle [31:0]
   output logic [HANDLE_WIDTH-1:0] rsp_tdata,
   // result_kind [2:0]
   output logic [CODE_WIDTH-1:0]   rsp_tuser,
   output logic                    rsp_tlast,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [LEAD_WIDTH-1:0]   csr_data
);

   chain_ctl_type        ctl;
   logic [CNT_WIDTH-1:0] cnt;
   entry_type            cell_q [DEPTH];

   ptt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .head       (cell_q[0]),
      .ctl        (ctl),
      .cnt        (cnt)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type nbr;
      if (i == DEPTH - 1) begin : g_end
         // The last cell is only ever the tail, so it never shifts from a neighbor.
         assign nbr = cell_q[i];
      end else begin : g_mid
         assign nbr = cell_q[i+1];
      end

      ptt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .idx   (CNT_WIDTH'(i)),
         .cnt   (cnt),
         .ctl   (ctl),
         .nbr   (nbr),
         .entry (cell_q[i])
      );
   end

endmodule

### hw/rtl/ptt_checker.sv
// ---------------------------------------------------------------------------
// Periodic timer table checker
// Port-level properties of the timer table, bound to the top level.
// ---------------------------------------------------------------------------
module ptt_checker
   import ptt_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [HANDLE_WIDTH-1:0] rsp_tdata,
   input logic [CODE_WIDTH-1:0]   rsp_tuser,
   input logic                    rsp_tlast
);

   // A held result keeps its contents until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Only fire results can be followed by more results of the same request.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_FIRED) |-> rsp_tlast)
      else $error("non-fire result without last mark");

   // A table full result never names a handle.
   a_full_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_FULL) |-> (rsp_tdata == '0))
      else $error("table full result carries a handle");

   // The table works on one request at a time.
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another is in progress");

endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
